/* design/tac_pkg.sv */
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types and constants of the turret aim command block.
// ----------------------------------------------------------------------------
package tac_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int ROOT_TOP     = 24;
    localparam int POLY_DEG     = 6;
    localparam int STEP_W       = 6;

    typedef enum logic [1:0] {
        FUNC_TARGET = 2'd0,
        FUNC_JOY    = 2'd1,
        FUNC_MODE   = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_MAX_ELEV = 2'd0,
        REG_MAX_TURN = 2'd1,
        REG_OFFSET   = 2'd2,
        REG_GEAR     = 2'd3
    } reg_index_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_ROOT, ST_CORD, ST_BEAR, ST_DIVE, ST_DONE_E,
        ST_DIVT, ST_DONE_T, ST_MODE, ST_PMLO, ST_PMHI, ST_PADD, ST_TICK, ST_GEAR
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SQX, OP_SQY, OP_ROOT, OP_CORD, OP_BEAR, OP_DIVE,
        OP_DONE_E, OP_DIVT, OP_DONE_T, OP_MODE, OP_PMLO, OP_PMHI, OP_PADD,
        OP_TICK, OP_GEAR
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
        logic hand;
    } status_t;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // Joystick divisors once the 2^16 part is folded into a shift, and their
    // reciprocals floor(2^32 / d).
    localparam logic [7:0]  DIV_ELEV = 8'd5;
    localparam logic [7:0]  DIV_TURN = 8'd180;
    localparam logic [31:0] RCP_ELEV = 32'd858993459;
    localparam logic [31:0] RCP_TURN = 32'd23860929;

endpackage

/* design/tac_ctrl.sv */
// ----------------------------------------------------------------------------
// tac_ctrl
// Sequencer that steps the datapath through each item's operations.
// ----------------------------------------------------------------------------
module tac_ctrl
    import tac_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [1:0] in_func,
    output logic       in_ready,
    input  status_t    status,
    output cmd_t       cmd
);

    localparam logic [STEP_W-1:0] ROOT_HI  = STEP_W'(ROOT_TOP);
    localparam logic [STEP_W-1:0] CORD_HI  = STEP_W'(CORDIC_STEPS - 1);
    localparam logic [STEP_W-1:0] POLY_HI  = STEP_W'(POLY_DEG);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd.op     = OP_NONE;
        cmd.step   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.op = OP_LOAD;
                    unique case (func_t'(in_func))
                        FUNC_TARGET: state_next = ST_SQX;
                        FUNC_JOY:    state_next = ST_DIVE;
                        FUNC_MODE:   state_next = ST_MODE;
                        FUNC_TICK: begin
                            state_next = status.hand ? ST_TICK : ST_PMLO;
                            cnt_next   = STEP_W'(1);
                        end
                    endcase
                end
            end
            ST_SQX: begin
                cmd.op     = OP_SQX;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.op     = OP_SQY;
                state_next = ST_ROOT;
                cnt_next   = ROOT_HI;
            end
            ST_ROOT: begin
                cmd.op = OP_ROOT;
                if (cnt_reg == '0) begin
                    state_next = ST_CORD;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_CORD: begin
                cmd.op = OP_CORD;
                if (cnt_reg == CORD_HI) begin
                    state_next = ST_BEAR;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_BEAR: begin
                cmd.op     = OP_BEAR;
                state_next = ST_IDLE;
            end
            ST_DIVE: begin
                cmd.op     = OP_DIVE;
                state_next = ST_DONE_E;
            end
            ST_DONE_E: begin
                cmd.op     = OP_DONE_E;
                state_next = ST_DIVT;
            end
            ST_DIVT: begin
                cmd.op     = OP_DIVT;
                state_next = ST_DONE_T;
            end
            ST_DONE_T: begin
                cmd.op     = OP_DONE_T;
                state_next = ST_IDLE;
            end
            ST_MODE: begin
                cmd.op     = OP_MODE;
                state_next = ST_IDLE;
            end
            ST_PMLO: begin
                cmd.op     = OP_PMLO;
                state_next = ST_PMHI;
            end
            ST_PMHI: begin
                cmd.op     = OP_PMHI;
                state_next = ST_PADD;
            end
            ST_PADD: begin
                cmd.op = OP_PADD;
                if (cnt_reg == POLY_HI) begin
                    state_next = ST_TICK;
                end else begin
                    state_next = ST_PMLO;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            ST_TICK: begin
                cmd.op     = OP_TICK;
                state_next = ST_GEAR;
            end
            ST_GEAR: begin
                // Hold here while the previous word still sits unaccepted.
                if (!status.out_busy) begin
                    cmd.op     = OP_GEAR;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* design/tac_datapath.sv */
// ----------------------------------------------------------------------------
// tac_datapath
// Registers, arithmetic units and result register of the aim command block.
// ----------------------------------------------------------------------------
module tac_datapath
    import tac_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic signed [23:0] in_x,
    input  logic signed [23:0] in_y,
    input  logic signed [15:0] in_ea,
    input  logic signed [15:0] in_ta,
    input  logic               in_hand,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [30:0]        out_elev,
    output logic [30:0]        out_turn
);

    localparam int BW    = FRAC_BITS + 2;

    localparam logic signed [63:0] SAT_P = 64'sd1 <<< 62;
    localparam logic signed [63:0] SAT_N = -(64'sd1 <<< 62);
    localparam logic signed [63:0] ONE_F = 64'sd1 <<< FRAC_BITS;

    localparam logic signed [63:0] COEF [POLY_DEG+1] = '{
        -((64'sd4475  * ONE_F + 64'sd5000) / 64'sd10000),
         ((64'sd52814 * ONE_F + 64'sd5000) / 64'sd10000),
        -((64'sd24424 * ONE_F + 64'sd500) / 64'sd1000),
         ((64'sd56043 * ONE_F + 64'sd500) / 64'sd1000),
        -((64'sd67331 * ONE_F + 64'sd500) / 64'sd1000),
         ((64'sd44159 * ONE_F + 64'sd500) / 64'sd1000),
        -((64'sd10077 * ONE_F + 64'sd500) / 64'sd1000)
    };

    // Configuration registers.
    logic [30:0]        max_elev_reg, max_turn_reg;
    logic signed [17:0] offset_reg;
    logic [15:0]        gear_reg;

    // Item and working registers.
    logic signed [23:0] x_reg, y_reg;
    logic signed [15:0] ea_reg, ta_reg;
    logic               hmode_reg;
    logic [48:0]        v_reg;
    logic [24:0]        r_reg;
    logic signed [27:0] cx_reg, cy_reg;
    logic signed [32:0] z_reg;
    logic [23:0]        jn_reg, jq_reg;
    logic signed [63:0] acc_reg;
    logic [55:0]        plo_reg;
    logic [54:0]        phi_reg;

    // Architectural state.
    logic [23:0]        range_reg;
    logic signed [BW-1:0] bear_reg;
    logic signed [31:0] eacc_reg, tacc_reg;
    logic               hand_reg;
    logic               ov_reg;
    logic [30:0]        oe_reg, ot_reg;

    function automatic logic [30:0] clamp_cmd(input logic signed [63:0] v,
                                              input logic [30:0] hi);
        logic [30:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({33'd0, hi})) begin
            res = hi;
        end else begin
            res = v[30:0];
        end
        return res;
    endfunction

    function automatic logic [15:0] mag16(input logic signed [15:0] a);
        return a[15] ? 16'(-a) : a;
    endfunction

    function automatic logic [23:0] mag24(input logic signed [23:0] a);
        return a[23] ? 24'(-a) : a;
    endfunction

    // Magnitude of the axis times 2^FRAC_BITS / 2^16, rounded down.
    function automatic logic [23:0] joy_scale(input logic [15:0] m);
        logic [39:0] w;
        w = (40'(m) << FRAC_BITS) >> 16;
        return w[23:0];
    endfunction

    function automatic logic signed [31:0] add_div(input logic signed [31:0] a,
                                                   input logic [23:0] q,
                                                   input logic neg);
        logic signed [33:0] qs;
        logic signed [33:0] s;
        logic signed [31:0] res;
        qs = $signed({10'd0, q});
        if (neg) begin
            qs = -qs;
        end
        s = 34'(a) + qs;
        if (s > 34'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (s < -34'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = s[31:0];
        end
        return res;
    endfunction

    // Integer square root, one result bit per step.
    logic [24:0] trial;
    logic [49:0] trial_sq;
    assign trial    = r_reg | (25'd1 << cmd.step[4:0]);
    assign trial_sq = trial * trial;

    logic signed [47:0] sq_x, sq_y;
    assign sq_x = x_reg * x_reg;
    assign sq_y = y_reg * y_reg;

    // CORDIC vectoring step.
    logic signed [27:0] sh_x, sh_y;
    logic signed [32:0] atan_s;
    assign sh_x   = cx_reg >>> cmd.step[4:0];
    assign sh_y   = cy_reg >>> cmd.step[4:0];
    assign atan_s = $signed({1'b0, ATAN_TAB[cmd.step[4:0]]});

    // Bearing from the final angle.
    logic [30:0]          zc;
    logic [32:0]          zr;
    logic signed [BW-1:0] bear_mag, bear_new;
    always_comb begin
        if (z_reg < 0) begin
            zc = '0;
        end else if (z_reg > 33'sd1073741824) begin
            zc = 31'd1073741824;
        end else begin
            zc = z_reg[30:0];
        end
        zr       = ({2'b00, zc} + (33'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
        bear_mag = $signed(zr[BW-1:0]);
        if (y_reg == 0) begin
            bear_new = '0;
        end else if (x_reg == 0) begin
            bear_new = y_reg[23] ? -(BW'(1) <<< (FRAC_BITS - 2))
                                 : (BW'(1) <<< (FRAC_BITS - 2));
        end else if (x_reg[23] != y_reg[23]) begin
            bear_new = -bear_mag;
        end else begin
            bear_new = bear_mag;
        end
    end

    // Joystick division by a small constant through its reciprocal. The
    // estimate is at most one low; the next cycle corrects it and adds it to
    // the accumulator.
    logic [23:0] j_n;
    logic [31:0] j_rcp;
    logic [55:0] j_prod;
    logic [7:0]  j_d;
    logic [23:0] j_qd, j_rem, j_q;
    assign j_n    = joy_scale(mag16((cmd.op == OP_DIVT) ? ta_reg : ea_reg));
    assign j_rcp  = (cmd.op == OP_DIVT) ? RCP_TURN : RCP_ELEV;
    assign j_prod = j_n * j_rcp;
    assign j_d    = (cmd.op == OP_DONE_T) ? DIV_TURN : DIV_ELEV;
    assign j_qd   = jq_reg * {16'd0, j_d};
    assign j_rem  = jn_reg - j_qd;
    assign j_q    = jq_reg + {23'd0, (j_rem >= {16'd0, j_d})};

    // Horner step: magnitude times range, rounded, plus the next coefficient.
    logic [63:0]        mag;
    logic [87:0]        full;
    logic [63:0]        prod;
    logic signed [64:0] hsum;
    logic signed [63:0] hnext;
    always_comb begin
        mag  = acc_reg[63] ? 64'(-acc_reg) : acc_reg;
        full = {1'b0, phi_reg, 32'd0} + {32'd0, plo_reg};
        if (full > 88'(SAT_P)) begin
            prod = SAT_P;
        end else begin
            prod = 64'((full + (88'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        end
        hsum = (acc_reg[63] ? -$signed({1'b0, prod}) : $signed({1'b0, prod}))
               + 65'(COEF[cmd.step[2:0]]);
        if (hsum > 65'(SAT_P)) begin
            hnext = SAT_P;
        end else if (hsum < 65'(SAT_N)) begin
            hnext = SAT_N;
        end else begin
            hnext = hsum[63:0];
        end
    end

    // Tick: clamp and write back.
    logic [30:0] elev_new, turn_new;
    always_comb begin
        if (hand_reg) begin
            elev_new = clamp_cmd(64'(eacc_reg), max_elev_reg);
            turn_new = clamp_cmd(64'(tacc_reg), max_turn_reg);
        end else begin
            elev_new = clamp_cmd(acc_reg, max_elev_reg);
            turn_new = clamp_cmd(64'(bear_reg) - 64'(offset_reg), max_turn_reg);
        end
    end

    logic [46:0] geared;
    logic [38:0] geared_sh;
    assign geared    = tacc_reg[30:0] * gear_reg;
    assign geared_sh = geared[46:8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_elev_reg <= 31'd655360;
            max_turn_reg <= 31'd65536;
            offset_reg   <= '0;
            gear_reg     <= 16'd256;
            range_reg    <= '0;
            bear_reg     <= '0;
            eacc_reg     <= '0;
            tacc_reg     <= '0;
            hand_reg     <= 1'b1;
            ov_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (reg_index_t'(cfg_index))
                    REG_MAX_ELEV: max_elev_reg <= cfg_data;
                    REG_MAX_TURN: max_turn_reg <= cfg_data;
                    REG_OFFSET:   offset_reg   <= $signed(cfg_data[17:0]);
                    REG_GEAR:     gear_reg     <= cfg_data[15:0];
                endcase
            end
            if (cmd.op == OP_GEAR) begin
                ov_reg <= 1'b1;
            end else if (ov_reg && out_ready) begin
                ov_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_BEAR: begin
                    range_reg <= r_reg[23:0];
                    bear_reg  <= bear_new;
                end
                OP_DONE_E: eacc_reg <= add_div(eacc_reg, j_q, ea_reg[15]);
                OP_DONE_T: tacc_reg <= add_div(tacc_reg, j_q, ta_reg[15]);
                OP_MODE:   hand_reg <= hmode_reg;
                OP_TICK: begin
                    eacc_reg <= $signed({1'b0, elev_new});
                    tacc_reg <= $signed({1'b0, turn_new});
                end
                default: ;
            endcase
        end
    end

    // Working registers carry no reset.
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                x_reg     <= in_x;
                y_reg     <= in_y;
                ea_reg    <= in_ea;
                ta_reg    <= in_ta;
                hmode_reg <= in_hand;
                r_reg     <= '0;
                cx_reg    <= $signed({4'd0, mag24(in_x)});
                cy_reg    <= $signed({4'd0, mag24(in_y)});
                z_reg     <= '0;
                acc_reg   <= COEF[0];
            end
            OP_SQX: v_reg <= {1'b0, sq_x[47:0]};
            OP_SQY: v_reg <= v_reg + {1'b0, sq_y[47:0]};
            OP_ROOT: begin
                if (trial_sq <= {1'b0, v_reg}) begin
                    r_reg <= trial;
                end
            end
            OP_CORD: begin
                if (cy_reg > 0) begin
                    cx_reg <= cx_reg + sh_y;
                    cy_reg <= cy_reg - sh_x;
                    z_reg  <= z_reg + atan_s;
                end else begin
                    cx_reg <= cx_reg - sh_y;
                    cy_reg <= cy_reg + sh_x;
                    z_reg  <= z_reg - atan_s;
                end
            end
            OP_DIVE, OP_DIVT: begin
                jn_reg <= j_n;
                jq_reg <= j_prod[55:32];
            end
            OP_PMLO: plo_reg <= mag[31:0] * range_reg;
            OP_PMHI: phi_reg <= mag[62:32] * range_reg;
            OP_PADD: acc_reg <= hnext;
            OP_GEAR: begin
                oe_reg <= eacc_reg[30:0];
                ot_reg <= (geared_sh > 39'h7FFFFFFF) ? 31'h7FFFFFFF : geared_sh[30:0];
            end
            default: ;
        endcase
    end

    assign status.out_busy = ov_reg && !out_ready;
    assign status.hand     = hand_reg;
    assign out_valid       = ov_reg;
    assign out_elev        = oe_reg;
    assign out_turn        = ot_reg;

endmodule

/* design/turret_aim_command_top.sv */
// ----------------------------------------------------------------------------
// turret_aim_command_top
// Turret aim command block: target geometry, joystick nudges, aim commands.
// ----------------------------------------------------------------------------
// A target word passes through the accepting cycle, the squaring of both
// coordinates, 25 square-root steps, 30 CORDIC steps and a store. A
// joystick word takes, for each axis, a reciprocal multiply and then a step
// that corrects the quotient and adds it to the accumulator. A mode word
// stores the mode. A tick word clamps, gears and loads the output; in
// automatic mode six Horner steps come first, each a low multiply, a high
// multiply and an add (the 63-bit magnitude times the 24-bit range, split
// into its low 32 and high 31 bits). The load waits on an unaccepted result.
// Input is taken only between words; the result register lets a new word
// enter while an earlier result waits on the output.
module turret_aim_command_top
    import tac_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_position[23:0], y_position[47:24], elev_axis[63:48],
    // turn_axis[79:64], hand_mode[80], zero fill
    input  logic [87:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // elev_command[30:0], turn_command[61:31], zero fill
    output logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    cmd_t        cmd;
    status_t     status;
    logic [30:0] out_elev, out_turn;

    tac_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_func  (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tac_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_x      ($signed(s_tdata[23:0])),
        .in_y      ($signed(s_tdata[47:24])),
        .in_ea     ($signed(s_tdata[63:48])),
        .in_ta     ($signed(s_tdata[79:64])),
        .in_hand   (s_tdata[80]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_elev  (out_elev),
        .out_turn  (out_turn)
    );

    assign m_tdata = {2'b00, out_turn, out_elev};

    // Every word keeps the sequencer busy in the cycle after it is accepted.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A result appears only from the output load of a tick.
    a_result_from_gear: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.op == OP_GEAR))
        else $error("result word appeared without an output load");

endmodule

/* tb/turret_aim_command_checker.sv */
// ----------------------------------------------------------------------------
// turret_aim_command_checker
// Watches the input, result and register ports of the turret aim command
// block, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module turret_aim_command_checker
    import tac_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam longint SAT = longint'(1) << 62;

    typedef struct {
        logic [30:0] elev;
        logic [30:0] turn;
    } aim_t;

    aim_t aim_queue[$];

    logic [30:0]  lim_elev, lim_turn;
    logic [15:0]  gear;
    longint       offset;
    longint       range_q, bearing_q;
    longint       elev_acc, turn_acc;
    logic         hand;

    function automatic longint root_of(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint angle_of(longint x, longint y);
        longint ax, ay, z, nx, r;
        z = 0;
        if (y == 0) return 0;
        if (x == 0) return (y > 0) ? 16384 : -16384;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (ay > 0) begin
                nx = ax + (ay >>> i);
                ay = ay - (ax >>> i);
                z  = z + longint'(ATAN_TAB[i]);
            end else begin
                nx = ax - (ay >>> i);
                ay = ay + (ax >>> i);
                z  = z - longint'(ATAN_TAB[i]);
            end
            ax = nx;
        end
        if (z < 0) z = 0;
        if (z > (longint'(1) << 30)) z = longint'(1) << 30;
        r = (z + (longint'(1) << 15)) >>> 16;
        if ((x < 0) != (y < 0)) r = -r;
        return r;
    endfunction

    function automatic longint coef(int k);
        longint num[7];
        longint den[7];
        longint m;
        num = '{-4475, 52814, -24424, 56043, -67331, 44159, -10077};
        den = '{10000, 10000, 1000, 1000, 1000, 1000, 1000};
        m = (num[k] < 0) ? -num[k] : num[k];
        m = (m * 65536 + den[k] / 2) / den[k];
        return (num[k] < 0) ? -m : m;
    endfunction

    function automatic longint elev_curve(longint d);
        longint acc, mag, prod;
        acc = coef(0);
        for (int k = 1; k < 7; k++) begin
            mag = (acc < 0) ? -acc : acc;
            if (d != 0 && mag > SAT / d) prod = SAT;
            else prod = (mag * d + 32768) >>> 16;
            acc = (acc < 0) ? -prod : prod;
            acc = acc + coef(k);
            if (acc > SAT) acc = SAT;
            if (acc < -SAT) acc = -SAT;
        end
        return acc;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        longint s;
        s = a + b;
        if (s > 64'sd2147483647) return 64'sd2147483647;
        if (s < -64'sd2147483648) return -64'sd2147483648;
        return s;
    endfunction

    function automatic longint clamp(longint v, logic [30:0] hi);
        if (v < 0) return 0;
        if (v > longint'(hi)) return longint'(hi);
        return v;
    endfunction

    task automatic report(string what, logic [30:0] got, logic [30:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    task automatic take_word(logic [1:0] fn, logic [87:0] d);
        longint x, y, ea, ta, t;
        aim_t a;
        x  = longint'($signed(d[23:0]));
        y  = longint'($signed(d[47:24]));
        ea = longint'($signed(d[63:48]));
        ta = longint'($signed(d[79:64]));
        case (func_t'(fn))
            FUNC_TARGET: begin
                range_q   = root_of(x * x + y * y) & 64'hFFFFFF;
                bearing_q = angle_of(x, y);
            end
            FUNC_JOY: begin
                elev_acc = add_sat(elev_acc, ea * 65536 / 327680);
                turn_acc = add_sat(turn_acc, ta * 65536 / 11796480);
            end
            FUNC_MODE: hand = d[80];
            default: begin
                if (hand) begin
                    elev_acc = clamp(elev_acc, lim_elev);
                    turn_acc = clamp(turn_acc, lim_turn);
                end else begin
                    elev_acc = clamp(elev_curve(range_q), lim_elev);
                    turn_acc = clamp(bearing_q - offset, lim_turn);
                end
                t = (turn_acc * longint'(gear)) >>> 8;
                if (t > 64'h7FFFFFFF) t = 64'h7FFFFFFF;
                a.elev = elev_acc[30:0];
                a.turn = t[30:0];
                aim_queue.push_back(a);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        aim_t want;
        if (!aresetn) begin
            fail_count = 0;
            lim_elev  = 31'd655360;
            lim_turn  = 31'd65536;
            offset    = 0;
            gear      = 16'd256;
            range_q   = 0;
            bearing_q = 0;
            elev_acc  = 0;
            turn_acc  = 0;
            hand      = 1'b1;
        end else begin
            if (cfg_we) begin
                case (reg_index_t'(cfg_index))
                    REG_MAX_ELEV: lim_elev = cfg_data;
                    REG_MAX_TURN: lim_turn = cfg_data;
                    REG_OFFSET:   offset = longint'($signed(cfg_data[17:0]));
                    default:      gear = cfg_data[15:0];
                endcase
            end
            if (s_tvalid && s_tready) take_word(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (aim_queue.size() == 0) begin
                    report("unexpected result word", m_tdata[30:0], '0);
                end else begin
                    want = aim_queue.pop_front();
                    if (m_tdata[30:0] !== want.elev)
                        report("elev_command", m_tdata[30:0], want.elev);
                    if (m_tdata[61:31] !== want.turn)
                        report("turn_command", m_tdata[61:31], want.turn);
                end
            end
        end
        pending = aim_queue.size();
    end

endmodule

/* tb/turret_aim_command_top_test.sv */
// ----------------------------------------------------------------------------
// turret_aim_command_top_test
// Drives target, joystick, mode and tick words into the turret aim command
// block under random idling and several register settings; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module turret_aim_command_top_test;
    import tac_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          quiet = 0;
    bit          gaps_on = 1'b1;

    turret_aim_command_top u_top (.*);

    turret_aim_command_checker u_check (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk)
        m_tready <= gaps_on ? ($urandom_range(99) >= 35) : 1'b1;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("** turret_aim_command_top: FAILED **");
            $finish;
        end
    end

    task automatic send_word(func_t fn, logic [23:0] x, logic [23:0] y,
                             logic [15:0] ea, logic [15:0] ta, logic hm);
        while (gaps_on && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {7'd0, hm, ta, ea, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic rand_word();
        int          pick;
        logic [23:0] x, y;
        logic [15:0] ea, ta;
        logic        hm;
        pick = $urandom_range(99);
        x  = 24'($urandom);
        y  = 24'($urandom);
        ea = 16'($urandom);
        ta = 16'($urandom);
        hm = 1'($urandom);
        // Small coordinates keep the elevation curve in its useful span.
        if ($urandom_range(1) != 0) begin
            x = 24'($signed(x[19:0]));
            y = 24'($signed(y[19:0]));
        end
        if (pick < 25)      send_word(FUNC_TARGET, x, y, ea, ta, hm);
        else if (pick < 45) send_word(FUNC_JOY, x, y, ea, ta, hm);
        else if (pick < 58) send_word(FUNC_MODE, x, y, ea, ta, hm);
        else                send_word(FUNC_TICK, x, y, ea, ta, hm);
    endtask

    // The block may still be busy on a word without a result, so hold off a
    // little longer than a target word takes before touching registers.
    task automatic set_regs(logic [30:0] me, logic [30:0] mt, logic [30:0] off,
                            logic [30:0] gr);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_data  <= (i == 0) ? me : (i == 1) ? mt : (i == 2) ? off : gr;
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed words at reset settings.
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_JOY, '0, '0, 16'h7FFF, 16'h7FFF, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_JOY, '0, '0, 16'h8000, 16'h8000, 1'b0);
        send_word(FUNC_JOY, '0, '0, 16'h8000, 16'h8000, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b1);
        send_word(FUNC_MODE, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_TARGET, 24'h7FFFFF, 24'h7FFFFF, '0, '0, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_TARGET, 24'h800000, 24'h800000, '0, '0, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_TARGET, '0, 24'h010000, '0, '0, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_TARGET, '0, 24'hFF0000, '0, '0, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_TARGET, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_TARGET, 24'h030000, '0, '0, '0, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_TARGET, 24'hFD0000, 24'h020000, '0, '0, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_TARGET, 24'h020000, 24'hFD0000, '0, '0, 1'b0);
        send_word(FUNC_TICK, '0, '0, '0, '0, 1'b0);
        send_word(FUNC_MODE, '0, '0, '0, '0, 1'b1);

        set_regs(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h30000, 31'hFFFF);
        for (int n = 0; n < 100; n++) rand_word();
        set_regs('0, '0, 31'h10000, '0);
        for (int n = 0; n < 60; n++) rand_word();
        gaps_on = 1'b0;
        set_regs(31'($urandom), 31'($urandom_range(131072)), 31'($urandom),
                 31'($urandom));
        for (int n = 0; n < 100; n++) rand_word();
        gaps_on = 1'b1;
        set_regs(31'd655360, 31'd65536, 31'h1000, 31'd256);
        for (int n = 0; n < 140; n++) rand_word();

        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("** turret_aim_command_top: PASSED **");
        end else begin
            $display("** turret_aim_command_top: FAILED **");
        end
        $finish;
    end

endmodule

/* turret_aim_command_top.f */
design/tac_pkg.sv
design/tac_ctrl.sv
design/tac_datapath.sv
design/turret_aim_command_top.sv
tb/turret_aim_command_checker.sv
tb/turret_aim_command_top_test.sv
